### rtl/core/wsti_pkg.sv
// ============================================================================
// wsti_pkg: shared types, constants and curve table builder
// Holds the configuration word type and the elaboration-time functions that
// compute the fixed tanh transfer curves entry by entry in Q30.
// ============================================================================
package wsti_pkg;

  localparam int Curves              = 5;
  localparam int TableEntriesDefault = 256;
  localparam logic [2:0] CurveHarsh  = 3'd4;

  localparam logic [63:0] OneQ30   = 64'd1073741824;
  localparam logic [63:0] ExpM1Q30 = 64'd395007542;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgCurveSelect = 2'd0,
    CfgDryGain     = 2'd1,
    CfgWetGain     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  curve_select;
    logic [15:0] dry_gain;
    logic [15:0] wet_gain;
  } cfg_t;

  function automatic logic [63:0] curve_gain_q30(input int c);
    case (c)
      0:       return 64'd1409860903;
      1:       return 64'd1170734438;
      2:       return 64'd1077759630;
      3:       return 64'd1073915139;
      default: return 64'd1073749313;
    endcase
  endfunction

  // Twice the slope of each curve in Q30: 2, pi, 2pi, 3pi, 4pi.
  function automatic logic [63:0] curve_twoa_q30(input int c);
    case (c)
      0:       return 64'd2147483648;
      1:       return 64'd3373259426;
      2:       return 64'd6746518852;
      3:       return 64'd10119778279;
      default: return 64'd13493037705;
    endcase
  endfunction

  // Truncating division by the Taylor term number.
  function automatic logic [63:0] div_term(input logic [63:0] x, input int k);
    case (k)
      2:       return x / 2;
      3:       return x / 3;
      4:       return x / 4;
      5:       return x / 5;
      6:       return x / 6;
      7:       return x / 7;
      8:       return x / 8;
      9:       return x / 9;
      10:      return x / 10;
      11:      return x / 11;
      12:      return x / 12;
      default: return x;
    endcase
  endfunction

  // Restoring shift-subtract division, truncating.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-z for z >= 0, both in Q30.
  function automatic logic [63:0] neg_exp_q30(input logic [63:0] z);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    n    = z >> 30;
    f    = z & (OneQ30 - 64'd1);
    term = OneQ30;
    pos  = OneQ30;
    neg  = '0;
    for (int k = 1; k <= 12; k++) begin
      term = div_term((term * f) >> 30, k);
      if ((k % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = pos - neg;
    for (int k = 0; k < 64; k++) begin
      if (64'(k) < n) begin
        r = (r * ExpM1Q30) >> 30;
      end
    end
    return r;
  endfunction

  // Entry i of curve c for a table of n entries, signed Q1.15.
  function automatic logic signed [15:0] curve_entry(input int c, input int i, input int n);
    int          num;
    logic        negative;
    logic [63:0] mag;
    logic [63:0] z;
    logic [63:0] e;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] q;
    num      = 2 * i - n;
    negative = (num < 0);
    mag      = negative ? 64'(-num) : 64'(num);
    z        = udiv64(curve_twoa_q30(c) * mag, 64'(n));
    e        = neg_exp_q30(z);
    t        = udiv64((OneQ30 - e) << 30, OneQ30 + e);
    v        = (t * curve_gain_q30(c)) >> 30;
    if (v > OneQ30) begin
      v = OneQ30;
    end
    q = (v + 64'd16384) >> 15;
    if (negative) begin
      return 16'(-q);
    end
    return (q > 64'd32767) ? 16'sd32767 : 16'(q);
  endfunction

endpackage

### rtl/core/wsti_rom.sv
// ============================================================================
// wsti_rom: transfer curve read-only memory
// All curves back to back, curve c at c*TableEntries. Two read ports with
// registered data, one for each interpolation neighbor.
// ============================================================================
module wsti_rom #(
  parameter int TableEntries = wsti_pkg::TableEntriesDefault,
  localparam int Depth = wsti_pkg::Curves * TableEntries,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  logic [AddrW-1:0]        rd0_addr_i,
  input  logic [AddrW-1:0]        rd1_addr_i,
  output logic signed [15:0]      rd0_data_o,
  output logic signed [15:0]      rd1_data_o
);

  typedef logic signed [15:0] rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int c = 0; c < wsti_pkg::Curves; c++) begin
      for (int i = 0; i < TableEntries; i++) begin
        r[c * TableEntries + i] = wsti_pkg::curve_entry(c, i, TableEntries);
      end
    end
    return r;
  endfunction

  localparam rom_t Rom = build_rom();

  logic signed [15:0] rd0_q;
  logic signed [15:0] rd1_q;

  always_ff @(posedge clk_i) begin
    rd0_q <= Rom[rd0_addr_i];
    rd1_q <= Rom[rd1_addr_i];
  end

  assign rd0_data_o = rd0_q;
  assign rd1_data_o = rd1_q;

endmodule

### rtl/core/wsti_lane.sv
// ============================================================================
// wsti_lane: one channel of the waveshaper
// Maps a sample onto the table, reads both neighbors, interpolates and mixes
// with the dry input. Five register stages; the result leaves unregistered.
// ============================================================================
module wsti_lane #(
  parameter int TableEntries = wsti_pkg::TableEntriesDefault
) (
  input  logic               clk_i,
  input  wsti_pkg::cfg_t     cfg_i,
  input  logic signed [15:0] sample_i,
  output logic signed [15:0] result_o
);

  localparam int IdxW  = $clog2(TableEntries);
  localparam int Depth = wsti_pkg::Curves * TableEntries;
  localparam int AddrW = $clog2(Depth);
  localparam int PW    = 16 + IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  // Stage 1: table position.
  logic [15:0]        offset;
  logic [PW-1:0]      pos;
  logic [IdxW-1:0]    idx_q;
  logic [15:0]        frac1_q;
  logic signed [15:0] s1_q;

  // Offset binary: s + 32768.
  assign offset = {~sample_i[15], sample_i[14:0]};
  assign pos    = PW'(offset) * PW'(TableEntries - 1);

  always_ff @(posedge clk_i) begin
    idx_q   <= pos[16 +: IdxW];
    frac1_q <= pos[15:0];
    s1_q    <= sample_i;
  end

  // Stage 2: curve memory read.
  logic [2:0]         curve;
  logic [AddrW-1:0]   base;
  logic [IdxW-1:0]    idx_hi;
  logic [AddrW-1:0]   addr_lo;
  logic [AddrW-1:0]   addr_hi;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic [15:0]        frac2_q;
  logic signed [15:0] s2_q;

  assign curve   = (cfg_i.curve_select > wsti_pkg::CurveHarsh) ? wsti_pkg::CurveHarsh
                                                               : cfg_i.curve_select;
  assign base    = AddrW'(curve) * AddrW'(TableEntries);
  assign idx_hi  = (idx_q == LastIdx) ? idx_q : idx_q + 1'b1;
  assign addr_lo = base + AddrW'(idx_q);
  assign addr_hi = base + AddrW'(idx_hi);

  wsti_rom #(
    .TableEntries(TableEntries)
  ) u_rom (
    .clk_i     (clk_i),
    .rd0_addr_i(addr_lo),
    .rd1_addr_i(addr_hi),
    .rd0_data_o(lo),
    .rd1_data_o(hi)
  );

  always_ff @(posedge clk_i) begin
    frac2_q <= frac1_q;
    s2_q    <= s1_q;
  end

  // Stage 3: slope times fraction.
  logic signed [16:0] diff;
  logic signed [33:0] slope_prod;
  logic signed [33:0] prod3_q;
  logic signed [15:0] lo3_q;
  logic signed [15:0] s3_q;

  assign diff       = 17'(hi) - 17'(lo);
  assign slope_prod = 34'(diff * $signed({1'b0, frac2_q}));

  always_ff @(posedge clk_i) begin
    prod3_q <= slope_prod;
    lo3_q   <= lo;
    s3_q    <= s2_q;
  end

  // Stage 4: interpolated value; the arithmetic shift floors the fraction.
  logic signed [17:0] shaped_sum;
  logic signed [15:0] shaped4_q;
  logic signed [15:0] s4_q;

  assign shaped_sum = 18'(lo3_q) + prod3_q[33:16];

  always_ff @(posedge clk_i) begin
    shaped4_q <= shaped_sum[15:0];
    s4_q      <= s3_q;
  end

  // Stage 5: wet and dry products.
  logic signed [32:0] wet_prod_q;
  logic signed [32:0] dry_prod_q;

  always_ff @(posedge clk_i) begin
    wet_prod_q <= 33'($signed({1'b0, cfg_i.wet_gain}) * shaped4_q);
    dry_prod_q <= 33'($signed({1'b0, cfg_i.dry_gain}) * s4_q);
  end

  // Mix, round half up, saturate.
  logic signed [34:0] acc;
  logic signed [19:0] scaled;

  assign acc    = 35'(wet_prod_q) + 35'(dry_prod_q) + 35'sd16384;
  assign scaled = acc[34:15];

  always_comb begin
    if (scaled > 20'sd32767) begin
      result_o = 16'sd32767;
    end else if (scaled < -20'sd32768) begin
      result_o = -16'sd32768;
    end else begin
      result_o = scaled[15:0];
    end
  end

endmodule

### rtl/core/waveshaper_table_interp_unit.sv
// ============================================================================
// waveshaper_table_interp_unit: stereo tanh table waveshaper
// Two lanes shape the left and right samples side by side; the result words
// are merged into one registered output word.
// ============================================================================
// Usage:
//   A stereo word is taken at a rising edge with start_i high and busy_o low.
//   busy_o is high during reset and only in the cycle after reset release; from
//   then on a word can be given in every cycle, one word per cycle sustained.
//   The result word appears on left_out_o and right_out_o for exactly one
//   cycle, marked by done_o. Its path runs through the lane pipeline
//   registers (table position, curve memory read, slope product,
//   interpolation, gain products) and then the output register.
//   There is no backpressure: the receiver must take every result word.
//   Configuration (cfg_we_i, cfg_addr_i, cfg_wdata_i) is written at a rising
//   edge and must only change while no word is in flight.
//   Reset clears the valid pipeline and loads curve 0, dry gain 0, wet gain 1.0.
//   The curves live in a read-only memory built at elaboration; no fill
//   pass is needed after reset.
// ============================================================================
module waveshaper_table_interp_unit #(
  parameter int TableEntries = wsti_pkg::TableEntriesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o
);

  localparam int Stages = 5;

  wsti_pkg::cfg_t cfg_q;
  logic           busy_q;
  logic           accept;
  logic [Stages-1:0] vld_q;
  logic           done_q;
  logic signed [15:0] left_res;
  logic signed [15:0] right_res;
  logic signed [15:0] left_q;
  logic signed [15:0] right_q;

  assign accept = start_i & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.curve_select <= 3'd0;
      cfg_q.dry_gain     <= 16'd0;
      cfg_q.wet_gain     <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        wsti_pkg::CfgCurveSelect: cfg_q.curve_select <= cfg_wdata_i[2:0];
        wsti_pkg::CfgDryGain:     cfg_q.dry_gain     <= cfg_wdata_i;
        wsti_pkg::CfgWetGain:     cfg_q.wet_gain     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[Stages-2:0], accept};
      done_q <= vld_q[Stages-1];
    end
  end

  wsti_lane #(
    .TableEntries(TableEntries)
  ) u_lane_left (
    .clk_i   (clk_i),
    .cfg_i   (cfg_q),
    .sample_i(left_sample_i),
    .result_o(left_res)
  );

  wsti_lane #(
    .TableEntries(TableEntries)
  ) u_lane_right (
    .clk_i   (clk_i),
    .cfg_i   (cfg_q),
    .sample_i(right_sample_i),
    .result_o(right_res)
  );

  // Merge both lanes into the output word.
  always_ff @(posedge clk_i) begin
    left_q  <= left_res;
    right_q <= right_res;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

  // Every accepted word produces exactly one result word.
  a_word_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_q)
    else $error("accepted word produced no result");

  a_no_spurious_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(accept, 6))
    else $error("result word without a matching input word");

  a_busy_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (vld_q == '0) && !done_q)
    else $error("pipeline not empty while busy after reset");

endmodule

### tb/sv/waveshaper_table_interp_unit_tb.sv
// ============================================================================
// waveshaper_table_interp_unit_tb: self-checking bench for the tanh shaper
// A short table of directed stereo words and register writes comes first. A
// set of random phases follows, each with its own curve and gain setting. Every
// accepted word without a known result is predicted by a local copy of the
// curve memory and interpolate-and-mix path; results are compared in order.
// ============================================================================
module waveshaper_table_interp_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableN        = 256;
  localparam int CurveCount    = 5;
  localparam int RandPhases    = 12;
  localparam int PhaseWords    = 100;
  localparam int CalmPhase     = 5;
  localparam int IdlePercent   = 16;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 12;

  localparam longint unsigned OneFix   = 64'd1073741824;
  localparam longint unsigned ExpM1Fix = 64'd395007542;

  // Index 3 decodes to no register.
  localparam logic [1:0] CfgSpare = 2'd3;

  typedef enum logic [2:0] {
    CrvFaint    = 3'd0,
    CrvLight    = 3'd1,
    CrvModerate = 3'd2,
    CrvHeavy    = 3'd3,
    CrvHarsh    = 3'd4,
    CrvOver     = 3'd7
  } curve_e;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] r;
  } stereo_t;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  addr;
    logic [15:0] data;
    stereo_t     smp;
    logic        typed;
    stereo_t     want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               busy_o;
  logic signed [15:0] left_sample_i  = '0;
  logic signed [15:0] right_sample_i = '0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_addr_i     = '0;
  logic [15:0]        cfg_wdata_i    = '0;
  logic               done_o;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;

  waveshaper_table_interp_unit #(
    .TableEntries(TableN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .left_sample_i (left_sample_i),
    .right_sample_i(right_sample_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o)
  );

  // Curve gains and twice the slopes, both in Q30.
  longint unsigned gain_fix [CurveCount] = '{
    64'd1409860903, 64'd1170734438, 64'd1077759630, 64'd1073915139, 64'd1073749313
  };
  longint unsigned twoa_fix [CurveCount] = '{
    64'd2147483648, 64'd3373259426, 64'd6746518852, 64'd10119778279, 64'd13493037705
  };

  logic signed [15:0] curve_tab [CurveCount][TableN];
  logic [2:0]         shadow_curve;
  logic [15:0]        shadow_dry;
  logic [15:0]        shadow_wet;

  stereo_t shaped_due [$];
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // e^-z with z and the result in Q30; every Taylor term is truncated.
  function automatic longint unsigned exp_neg_fix(input longint unsigned z);
    longint unsigned whole;
    longint unsigned part;
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    longint unsigned r;
    whole = z >> 30;
    part  = z & (OneFix - 64'd1);
    term  = OneFix;
    plus  = OneFix;
    minus = 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * part) >> 30) / longint'(k);
      if ((k % 2) == 1) begin
        minus += term;
      end else begin
        plus += term;
      end
    end
    r = plus - minus;
    for (longint unsigned j = 0; j < whole && j < 64; j++) begin
      r = (r * ExpM1Fix) >> 30;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] curve_point(input int c, input int i);
    longint          num;
    logic            negative;
    longint unsigned mag;
    longint unsigned z;
    longint unsigned e;
    longint unsigned t;
    longint unsigned v;
    longint unsigned q;
    num      = 2 * i - TableN;
    negative = (num < 0);
    mag      = negative ? -num : num;
    z        = twoa_fix[c] * mag / longint'(TableN);
    e        = exp_neg_fix(z);
    t        = ((OneFix - e) << 30) / (OneFix + e);
    v        = (t * gain_fix[c]) >> 30;
    if (v > OneFix) begin
      v = OneFix;
    end
    q = (v + 64'd16384) >> 15;
    if (negative) begin
      return 16'(-longint'(q));
    end
    return (q > 64'd32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic logic signed [15:0] shape_sample(input logic signed [15:0] s);
    int              crv;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned idx_hi;
    longint unsigned frac;
    longint          lo;
    longint          hi;
    longint          shaped;
    longint          acc;
    crv    = (shadow_curve > CrvHarsh) ? int'(CrvHarsh) : int'(shadow_curve);
    pos    = longint'(int'(s) + 32768) * longint'(TableN - 1);
    idx    = pos >> 16;
    frac   = pos & 64'hFFFF;
    idx_hi = idx + 1;
    if (idx > TableN - 1) begin
      idx = TableN - 1;
    end
    if (idx_hi > TableN - 1) begin
      idx_hi = TableN - 1;
    end
    lo     = curve_tab[crv][idx];
    hi     = curve_tab[crv][idx_hi];
    shaped = lo + (((hi - lo) * longint'(frac)) >>> 16);
    acc    = longint'(shadow_wet) * shaped + longint'(shadow_dry) * longint'(s) + 16384;
    acc    = acc >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    if (acc < -32768) begin
      acc = -32768;
    end
    return 16'(acc);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(15))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] addr, input logic [15:0] data);
    dir_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.addr   = addr;
    row.data   = data;
    return row;
  endfunction

  function automatic dir_row_t word_row(input logic signed [15:0] l,
                                        input logic signed [15:0] r);
    dir_row_t row;
    row       = '{default: '0};
    row.smp.l = l;
    row.smp.r = r;
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic signed [15:0] l,
                                         input logic signed [15:0] r,
                                         input logic signed [15:0] want_l,
                                         input logic signed [15:0] want_r);
    dir_row_t row;
    row        = word_row(l, r);
    row.typed  = 1'b1;
    row.want.l = want_l;
    row.want.r = want_r;
    return row;
  endfunction

  // Holds start high until the word is taken, then books its expected result.
  // start is left high so that a following word goes out back to back.
  task automatic send_word(input stereo_t w, input logic typed, input stereo_t known);
    stereo_t due;
    start_i        <= 1'b1;
    left_sample_i  <= w.l;
    right_sample_i <= w.r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (typed) begin
      due = known;
    end else begin
      due.l = shape_sample(w.l);
      due.r = shape_sample(w.r);
    end
    shaped_due.push_back(due);
  endtask

  task automatic idle_cycle();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (shaped_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      wsti_pkg::CfgCurveSelect: shadow_curve = data[2:0];
      wsti_pkg::CfgDryGain:     shadow_dry   = data;
      wsti_pkg::CfgWetGain:     shadow_wet   = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Result checker and watchdog.
  always @(posedge clk_i) begin : check_results
    stereo_t want;
    if (rst_ni) begin
      if ((start_i && busy_o === 1'b0) || done_o === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (done_o === 1'b1) begin
        if (shaped_due.size() == 0) begin
          $display("%0t: unexpected result word, left %0d right %0d",
                   $time, left_out_o, right_out_o);
          mismatch_count++;
        end else begin
          want = shaped_due.pop_front();
          if (left_out_o !== want.l) begin
            $display("%0t: left_out expected %0d, got %0d", $time, want.l, left_out_o);
            mismatch_count++;
          end
          if (right_out_o !== want.r) begin
            $display("%0t: right_out expected %0d, got %0d", $time, want.r, right_out_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t    rows [$];
    stereo_t     w;
    logic [15:0] dry;
    logic [15:0] wet;

    for (int c = 0; c < CurveCount; c++) begin
      for (int i = 0; i < TableN; i++) begin
        curve_tab[c][i] = curve_point(c, i);
      end
    end
    shadow_curve = CrvFaint;
    shadow_dry   = 16'd0;
    shadow_wet   = 16'd32768;

    // Reset setting first, then each curve, then the gain extremes. With wet
    // at zero and dry at one the word passes through unchanged.
    rows.push_back(word_row(-16'sd32768, 16'sd32767));
    rows.push_back(word_row(16'sd0, -16'sd1));
    rows.push_back(word_row(16'sd1, 16'sd16384));
    rows.push_back(cfg_row(wsti_pkg::CfgCurveSelect, 16'(CrvLight)));
    rows.push_back(word_row(-16'sd16384, 16'sd12345));
    rows.push_back(cfg_row(wsti_pkg::CfgCurveSelect, 16'(CrvModerate)));
    rows.push_back(word_row(-16'sd300, 16'sd300));
    rows.push_back(cfg_row(wsti_pkg::CfgCurveSelect, 16'(CrvHeavy)));
    rows.push_back(word_row(16'sd32767, -16'sd32768));
    rows.push_back(cfg_row(wsti_pkg::CfgCurveSelect, 16'(CrvHarsh)));
    rows.push_back(word_row(-16'sd32768, 16'sd32767));
    rows.push_back(cfg_row(wsti_pkg::CfgCurveSelect, 16'(CrvOver)));
    rows.push_back(word_row(-16'sd32768, 16'sd32767));
    rows.push_back(word_row(16'sd4000, -16'sd4000));
    rows.push_back(cfg_row(wsti_pkg::CfgWetGain, 16'd0));
    rows.push_back(cfg_row(wsti_pkg::CfgDryGain, 16'd32768));
    rows.push_back(known_row(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767));
    rows.push_back(known_row(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA));
    rows.push_back(cfg_row(wsti_pkg::CfgDryGain, 16'hFFFF));
    rows.push_back(known_row(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768));
    rows.push_back(cfg_row(wsti_pkg::CfgDryGain, 16'd0));
    rows.push_back(known_row(16'sd12345, -16'sd12345, 16'sd0, 16'sd0));
    rows.push_back(cfg_row(CfgSpare, 16'hFFFF));
    rows.push_back(known_row(16'sd32767, -16'sd32768, 16'sd0, 16'sd0));
    rows.push_back(cfg_row(wsti_pkg::CfgWetGain, 16'hFFFF));
    rows.push_back(cfg_row(wsti_pkg::CfgDryGain, 16'hFFFF));
    rows.push_back(word_row(16'sd32767, -16'sd32768));
    rows.push_back(word_row(-16'sd20000, 16'sd20000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_results();
        write_reg(rows[i].addr, rows[i].data);
      end else begin
        send_word(rows[i].smp, rows[i].typed, rows[i].want);
      end
    end

    // Each phase waits for the pipeline to empty before it changes the setting.
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_results();
      if (ph == 1) begin
        dry = 16'hFFFF;
        wet = 16'd0;
      end else if (ph == 2) begin
        dry = 16'd0;
        wet = 16'hFFFF;
      end else begin
        dry = pick_gain();
        wet = pick_gain();
      end
      write_reg(wsti_pkg::CfgCurveSelect, {13'($urandom), 3'(ph)});
      write_reg(wsti_pkg::CfgDryGain, dry);
      write_reg(wsti_pkg::CfgWetGain, wet);
      if ($urandom_range(3) == 0) begin
        write_reg(CfgSpare, 16'($urandom));
      end
      for (int n = 0; n < PhaseWords; n++) begin
        while (ph != CalmPhase && $urandom_range(99) < IdlePercent) idle_cycle();
        w.l = rand_sample();
        w.r = rand_sample();
        send_word(w, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/wsti_pkg.sv
rtl/core/wsti_rom.sv
rtl/core/wsti_lane.sv
rtl/core/waveshaper_table_interp_unit.sv
tb/sv/waveshaper_table_interp_unit_tb.sv
